### sv/mdu_pkg.sv
// Shared types and constants for the modular division unit.
`default_nettype none
package mdu_pkg;
  localparam int unsigned WordW = 32;
  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
  localparam logic [1:0] STATUS_NOT_INV = 2'd2;

  // Datapath operation selected by the controller.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_RED_DEN,
    OP_RED_NUM,
    OP_EUCLID,
    OP_MUL,
    OP_RED_PROD
  } op_t;

  typedef struct packed {
    op_t  op;
    logic div_start;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic den_zero;
    logic mod_zero;
    logic nr_zero;
    logic r_is_one;
  } stat_t;
endpackage
`default_nettype wire

### sv/mdu_divider.sv
// Restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
`default_nettype none
module mdu_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic [63:0]      quotient,
  output logic [31:0]      remainder
);
  logic [6:0]  count;
  logic [32:0] rem_trial;

  assign rem_trial = {remainder, quotient[63]} - {1'b0, divisor};

  // Shift one dividend bit into the partial remainder per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy      <= 1'b1;
      count     <= 7'd64;
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      if (!rem_trial[32] || remainder[31]) begin
        remainder <= rem_trial[31:0];
        quotient  <= {quotient[62:0], 1'b1};
      end else begin
        remainder <= {remainder[30:0], quotient[63]};
        quotient  <= {quotient[62:0], 1'b0};
      end
      count <= count - 7'd1;
      if (count == 7'd1) begin
        busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

### sv/mdu_datapath.sv
// Datapath: operand registers, Euclid state and the shared divider.
`default_nettype none
module mdu_datapath (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mdu_pkg::cmd_t cmd,
  input  wire logic [63:0]   numerator,
  input  wire logic [63:0]   denominator,
  input  wire logic [31:0]   modulus,
  output mdu_pkg::stat_t     stat,
  output logic [31:0]        result
);
  import mdu_pkg::*;

  logic [63:0] num_mag;
  logic        num_neg;
  logic [63:0] den;
  logic [31:0] m;
  logic [31:0] r, nr;
  logic signed [33:0] t, nt;
  logic [31:0] n_res;
  logic [63:0] prod;
  logic [63:0] div_a;
  logic [31:0] div_b;
  logic        div_busy;
  logic [63:0] div_q;
  logic [31:0] div_r;
  logic signed [67:0] qt;
  logic signed [33:0] t_fix;

  // Divider operand selection follows the pending operation.
  always_comb begin
    div_b = m;
    unique case (cmd.op)
      OP_RED_DEN:  div_a = den;
      OP_RED_NUM:  div_a = num_mag;
      OP_RED_PROD: div_a = prod;
      OP_EUCLID: begin
        div_a = {32'd0, r};
        div_b = nr;
      end
      default:     div_a = den;
    endcase
  end

  mdu_divider u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(div_a),
    .divisor(div_b), .busy(div_busy), .quotient(div_q), .remainder(div_r)
  );

  assign qt = $signed({2'b00, div_q[31:0]}) * nt;
  assign t_fix = (t < 0) ? t + $signed({2'b00, m}) : t;

  // Results are captured when the divider has finished.
  always_ff @(posedge clk) begin
    if (!div_busy && !cmd.div_start) begin
      unique case (cmd.op)
        OP_LOAD: begin
          num_neg <= numerator[63];
          num_mag <= numerator[63] ? 64'd0 - numerator : numerator;
          den     <= denominator;
          m       <= modulus;
        end
        OP_RED_DEN: begin
          r  <= m;
          nr <= div_r;
          t  <= '0;
          nt <= 34'sd1;
        end
        OP_RED_NUM: n_res <= (num_neg && div_r != 0) ? m - div_r : div_r;
        OP_EUCLID: begin
          t  <= nt;
          nt <= t - qt[33:0];
          r  <= nr;
          nr <= div_r;
        end
        OP_MUL:      prod <= n_res * t_fix[31:0];
        OP_RED_PROD: result <= div_r;
        default: ;
      endcase
    end
  end

  assign stat.div_busy = div_busy;
  assign stat.den_zero = (den == 64'd0);
  assign stat.mod_zero = (m == 32'd0);
  assign stat.nr_zero  = (nr == 32'd0);
  assign stat.r_is_one = (r == 32'd1);
endmodule
`default_nettype wire

### sv/mdu_ctrl.sv
// Controller state machine sequencing reduction, Euclid and product steps.
`default_nettype none
module mdu_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_fire,
  input  wire logic           out_free,
  input  wire mdu_pkg::stat_t stat,
  output mdu_pkg::cmd_t       cmd,
  output logic                busy,
  output logic                done,
  output logic [1:0]          done_status
);
  import mdu_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_CHECK = 4'd1, S_RDEN = 4'd2,
    S_EUC = 4'd3, S_EUCW = 4'd4, S_RNUM = 4'd5, S_MUL = 4'd6,
    S_RPROD = 4'd7, S_DONE = 4'd8, S_ERR = 4'd9, S_RDENW = 4'd10,
    S_RNUMW = 4'd11, S_RPRODW = 4'd12;

  logic [3:0] state, state_next;
  logic [1:0] err_code;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd.op = OP_NONE;
    cmd.div_start = 1'b0;
    unique case (state)
      S_IDLE:  if (in_fire) begin cmd.op = OP_LOAD; state_next = S_CHECK; end
      S_CHECK: begin
        if (stat.den_zero || stat.mod_zero) state_next = S_ERR;
        else state_next = S_RDEN;
      end
      S_RDEN:  begin cmd.op = OP_RED_DEN; cmd.div_start = 1'b1; state_next = S_RDENW; end
      S_RDENW: begin cmd.op = OP_RED_DEN; if (!stat.div_busy) state_next = S_EUC; end
      S_EUC: begin
        if (stat.nr_zero) begin
          state_next = stat.r_is_one ? S_RNUM : S_ERR;
        end else begin
          cmd.op = OP_EUCLID; cmd.div_start = 1'b1; state_next = S_EUCW;
        end
      end
      S_EUCW:  begin cmd.op = OP_EUCLID; if (!stat.div_busy) state_next = S_EUC; end
      S_RNUM:  begin cmd.op = OP_RED_NUM; cmd.div_start = 1'b1; state_next = S_RNUMW; end
      S_RNUMW: begin cmd.op = OP_RED_NUM; if (!stat.div_busy) state_next = S_MUL; end
      S_MUL:   begin cmd.op = OP_MUL; state_next = S_RPROD; end
      S_RPROD: begin cmd.op = OP_RED_PROD; cmd.div_start = 1'b1; state_next = S_RPRODW; end
      S_RPRODW: begin cmd.op = OP_RED_PROD; if (!stat.div_busy) state_next = S_DONE; end
      S_DONE, S_ERR: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // State register and error code capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    if (state == S_CHECK) begin
      err_code <= stat.den_zero ? STATUS_ZERO_DEN : STATUS_NOT_INV;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = ((state == S_DONE) || (state == S_ERR)) && out_free;
  assign done_status = (state == S_DONE) ? STATUS_OK : err_code;
endmodule
`default_nettype wire

### sv/modular_division_unit_core.sv
// Top level of the modular division unit.
// Input channel: in_valid/in_stall with numerator (signed) and denominator.
// Output channel: out_valid/out_stall with residue, scalar_valid, status.
// Configuration: cfg_we/cfg_wdata write the modulus, reset value 1259713.
// One request is processed at a time; in_stall is high while busy.
// Each request runs division steps on a shared bit-serial divider:
// one for the denominator reduction, one per Euclid iteration (up to
// about 46 for a 32-bit modulus), one for the numerator reduction and one
// for the product reduction, plus control states. A zero denominator or
// a zero modulus ends the request before any division, while a shared
// factor shows only after Euclid. The result waits in an output register
// while out_stall is high. The controller goes idle once the result is in
// that register, so the next request is accepted and computed while it
// waits; a second result holds in the controller until the register
// drains. A new request is taken only once the previous result is in the
// output register. Synchronous reset clears control state and restores
// the modulus.
`default_nettype none
module modular_division_unit_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] numerator,
  input  wire logic [63:0] denominator,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      residue,
  output logic             scalar_valid,
  output logic [1:0]       status,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);
  import mdu_pkg::*;

  logic [31:0] modulus;
  cmd_t        cmd;
  stat_t       stat;
  logic        busy, done, in_fire, out_free;
  logic [1:0]  done_status;
  logic [31:0] result;

  assign in_stall = busy;
  assign in_fire  = in_valid && !busy;
  assign out_free = !out_valid || !out_stall;

  // Modulus register.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= 32'd1259713;
    end else if (cfg_we) begin
      modulus <= cfg_wdata;
    end
  end

  mdu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_free(out_free), .stat(stat),
    .cmd(cmd), .busy(busy), .done(done), .done_status(done_status)
  );

  mdu_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .numerator(numerator),
    .denominator(denominator), .modulus(modulus), .stat(stat), .result(result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (done) begin
      status       <= done_status;
      scalar_valid <= (done_status == STATUS_OK);
      residue      <= (done_status == STATUS_OK) ? result : 32'd0;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(residue))
    else $error("result changed under stall");
  a_ok_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (scalar_valid == (status == STATUS_OK)))
    else $error("valid flag mismatch");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |-> residue == 32'd0)
    else $error("error residue nonzero");
endmodule
`default_nettype wire
